/* design/rrts_pkg.sv */
// Shared constants, codes and types for the round-robin time-slice scheduler.
package rrts_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned WORK_W      = 16;
  localparam logic [WORK_W-1:0] SLICE_RESET = 16'd80;

  // action codes
  localparam logic ACT_ADD      = 1'b0;
  localparam logic ACT_DISPATCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // control from sequencer to every cell
  typedef struct packed {
    logic tok_load;
    logic tok_shift;
    logic tok_clr;
    logic scan;
  } cell_ctl_t;

  // status from one cell
  typedef struct packed {
    logic              hit;
    logic              pass;
    logic              wrap;
    logic [ID_W-1:0]   id;
    logic [WORK_W-1:0] give;
    logic              fin;
  } cell_out_t;

  typedef struct packed {
    logic              add_accepted;
    logic              granted;
    logic [ID_W-1:0]   granted_id;
    logic [WORK_W-1:0] slice_given;
    logic              task_finished;
    logic              all_done;
  } res_t;

endpackage

/* design/rrts_if.sv */
// Channel interfaces: task word in, result word out, time-slice write.
interface rrts_in_if import rrts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [ID_W-1:0]   task_id;
  logic [WORK_W-1:0] work_amount;
  modport source (output valid, action, task_id, work_amount, input ready);
  modport sink   (input valid, action, task_id, work_amount, output ready);
endinterface

interface rrts_out_if import rrts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              add_accepted;
  logic              granted;
  logic [ID_W-1:0]   granted_id;
  logic [WORK_W-1:0] slice_given;
  logic              task_finished;
  logic              all_done;
  modport source (output valid, add_accepted, granted, granted_id, slice_given,
                  task_finished, all_done, input ready);
  modport sink   (input valid, add_accepted, granted, granted_id, slice_given,
                  task_finished, all_done, output ready);
endinterface

interface rrts_cfg_if import rrts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORK_W-1:0] time_slice;
  modport source (output valid, time_slice, input ready);
  modport sink   (input valid, time_slice, output ready);
endinterface

/* design/round_robin_time_slice_scheduler_top.sv */
// Round-robin time-slice scheduler: sequencer over a ring of task cells.
//
//  channel  | dir | word                                        | taken when
//  ---------+-----+---------------------------------------------+------------------
//  in_ch    | in  | action, task_id, work_amount                | valid && ready
//  out_ch   | out | add_accepted, granted, granted_id,          | valid && ready
//           |     | slice_given, task_finished, all_done        |
//  cfg_ch   | in  | time_slice                                  | valid && ready
//
// Dispatch passes the token over k cells (1..entry count, at most QUEUE_DEPTH),
// one cell per cycle, then the done state and output register; an add skips it.
// A new word is taken only with the sequencer idle; the output register lets the
// next word in while a result waits. Result stalls hold the sequencer in its done
// state. Reset clears entry count, start slot and token; slice gets SLICE_RESET.
module round_robin_time_slice_scheduler_top import rrts_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  rrts_in_if.sink       in_ch,
  rrts_out_if.source    out_ch,
  rrts_cfg_if.sink      cfg_ch
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  state_t            st_r, st_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]     slot_r, slot_nxt;   // start of next search
  logic [IW-1:0]     pos_r, pos_nxt;     // token position
  logic [IW-1:0]     steps_r, steps_nxt;
  logic [WORK_W-1:0] slice_r;
  res_t              pend_r, pend_nxt;
  res_t              res_r;
  logic              out_valid_r;

  cell_ctl_t         ctl;
  cell_out_t         cells [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] tok_in, hits, wraps, wr_en, tok_ld, is_last;

  logic              in_take;
  logic              full;
  logic              hit_any;
  logic [ID_W-1:0]   hit_id;
  logic [WORK_W-1:0] hit_give;
  logic              hit_fin;
  logic              pos_last;
  logic              steps_last;
  logic              out_free;

  assign in_ch.ready  = (st_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign full         = (cnt_r == CW'(QUEUE_DEPTH));
  assign out_free     = !out_valid_r || out_ch.ready;
  assign pos_last     = ((CW'(pos_r) + CW'(1)) == cnt_r);
  assign steps_last   = ((CW'(steps_r) + CW'(1)) == cnt_r);

  // ring of cells, token handed on while scanning, wrapping at the last entry
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign wr_en[i]   = in_take && (in_ch.action == ACT_ADD) && !full &&
                        (cnt_r == CW'(i));
    assign tok_ld[i]  = (slot_r == IW'(i));
    assign is_last[i] = (cnt_r == CW'(i + 1));
    assign hits[i]    = cells[i].hit;
    assign wraps[i]   = cells[i].wrap;
    if (i == 0) begin : g_head
      assign tok_in[i] = |wraps;
    end else begin : g_body
      assign tok_in[i] = cells[i-1].pass;
    end

    rrts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl),
      .wr_en_i   (wr_en[i]),
      .wr_id_i   (in_ch.task_id),
      .wr_work_i (in_ch.work_amount),
      .slice_i   (slice_r),
      .tok_ld_i  (tok_ld[i]),
      .tok_in_i  (tok_in[i]),
      .is_last_i (is_last[i]),
      .out_o     (cells[i])
    );
  end

  // at most one cell holds the token, so an OR across hits selects it
  always_comb begin
    hit_any  = |hits;
    hit_id   = '0;
    hit_give = '0;
    hit_fin  = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_id   = hit_id   | (cells[i].id   & {ID_W{hits[i]}});
      hit_give = hit_give | (cells[i].give & {WORK_W{hits[i]}});
      hit_fin  = hit_fin  | (cells[i].fin  & hits[i]);
    end
  end

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    slot_nxt  = slot_r;
    pos_nxt   = pos_r;
    steps_nxt = steps_r;
    pend_nxt  = pend_r;
    ctl       = '0;
    case (st_r)
      ST_IDLE: begin
        if (in_take) begin
          pend_nxt = '0;
          if (in_ch.action == ACT_ADD) begin
            pend_nxt.add_accepted = !full;
            if (!full) begin
              cnt_nxt = cnt_r + CW'(1);
            end
            st_nxt = ST_DONE;
          end else if (cnt_r == '0) begin
            pend_nxt.all_done = 1'b1;
            st_nxt = ST_DONE;
          end else begin
            ctl.tok_load = 1'b1;
            pos_nxt   = slot_r;
            steps_nxt = '0;
            st_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (hit_any) begin
          ctl.tok_clr = 1'b1;
          pend_nxt.granted       = 1'b1;
          pend_nxt.granted_id    = hit_id;
          pend_nxt.slice_given   = hit_give;
          pend_nxt.task_finished = hit_fin;
          slot_nxt = pos_last ? '0 : pos_r + IW'(1);
          st_nxt   = ST_DONE;
        end else if (steps_last) begin
          ctl.tok_clr = 1'b1;
          pend_nxt.all_done = 1'b1;
          st_nxt = ST_DONE;
        end else begin
          ctl.tok_shift = 1'b1;
          pos_nxt   = pos_last ? '0 : pos_r + IW'(1);
          steps_nxt = steps_r + IW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      slot_r      <= '0;
      slice_r     <= SLICE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      slot_r <= slot_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        slice_r <= cfg_ch.time_slice;
      end
      if (st_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    steps_r <= steps_nxt;
    pend_r  <= pend_nxt;
    if (st_r == ST_DONE && out_free) begin
      res_r <= pend_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.add_accepted  = res_r.add_accepted;
  assign out_ch.granted       = res_r.granted;
  assign out_ch.granted_id    = res_r.granted_id;
  assign out_ch.slice_given   = res_r.slice_given;
  assign out_ch.task_finished = res_r.task_finished;
  assign out_ch.all_done      = res_r.all_done;

`ifndef SYNTHESIS
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_SCAN |-> $onehot(hits | wraps | tok_in | {QUEUE_DEPTH{1'b0}}) ||
                        $onehot0(hits))
    else $error("token not unique during scan");

  a_hits_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hits))
    else $error("more than one cell hit");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  a_grant_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.granted && res_r.all_done))
    else $error("grant and all-done together");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> (CW'(slot_r) < cnt_r))
    else $error("start slot outside stored entries");
`endif

endmodule

/* design/rrts_cell.sv */
// One ring cell: task id, remaining work and the scan token.
module rrts_cell import rrts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl_i,
  input  logic              wr_en_i,
  input  logic [ID_W-1:0]   wr_id_i,
  input  logic [WORK_W-1:0] wr_work_i,
  input  logic [WORK_W-1:0] slice_i,
  input  logic              tok_ld_i,
  input  logic              tok_in_i,
  input  logic              is_last_i,
  output cell_out_t         out_o
);

  logic              tok_r;
  logic [ID_W-1:0]   id_r;
  logic [WORK_W-1:0] work_r;
  logic [WORK_W-1:0] give;
  logic              hit;

  assign give = (slice_i < work_r) ? slice_i : work_r;
  assign hit  = tok_r && (work_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else if (ctl_i.tok_clr) begin
      tok_r <= 1'b0;
    end else if (ctl_i.tok_load) begin
      tok_r <= tok_ld_i;
    end else if (ctl_i.tok_shift) begin
      tok_r <= tok_in_i;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      id_r   <= wr_id_i;
      work_r <= wr_work_i;
    end else if (ctl_i.scan && hit) begin
      work_r <= work_r - give;
    end
  end

  always_comb begin
    out_o.hit  = hit;
    out_o.pass = tok_r && !is_last_i;
    out_o.wrap = tok_r && is_last_i;
    out_o.id   = id_r;
    out_o.give = give;
    out_o.fin  = (work_r == give);
  end

endmodule
